// ----- src/rmf_pkg.sv -----
// Shared types and constants for the running median filter.
// Holds the controller state type and the command and status bundles.
// No dependencies; every other file but rmf_checker imports this package.
package rmf_pkg;

  localparam int DEF_MAX_WINDOW = 9;
  localparam int DEF_CHANNELS   = 4;

  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 2;
  localparam int WSIZE_W  = 4;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DRAIN,
    ST_SORT,
    ST_FINISH
  } rmf_state_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic rd_en;
    logic sort_en;
    logic wr_front;
    logic out_load;
  } rmf_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic out_free;
  } rmf_status_t;

endpackage

// ----- src/running_median_filter.sv -----
// Top level of the running median filter.
// Depends on rmf_pkg, rmf_ctrl and rmf_datapath.
//
// Samples arrive on the input channel (in_valid, in_stall) with a channel
// number and a block end mark. Each channel keeps its own history; the new
// sample enters the front, and the median of the newest W samples leaves on
// the output channel (out_valid, out_stall) together with the block end mark.
// W comes from window_size, written over the cfg_valid/cfg_ready port while
// the block is idle; zero acts as one and values above MAX_WINDOW saturate.
// Each sample runs through the PREP, LOAD, DRAIN, SORT and FINISH states; W
// of one skips LOAD and DRAIN, and a channel at or above CHANNELS goes to
// FINISH and passes the sample through. The next sample is taken in IDLE.
// Work is set by the history memory, one entry per cycle, and by W passes of
// the odd-even sort cells. A finished result waits in the output register
// while the receiver stalls and the next sample is already accepted; only a
// second result waits for that register to drain. Reset sets W to three and
// makes every history read as zero until written again.
module running_median_filter
  import rmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [WSIZE_W-1:0]         window_size,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CHAN_W-1:0]          channel,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] median,
  output logic                       block_end_out
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(MAX_WINDOW);

  rmf_cmd_t      cmd;
  rmf_status_t   status;
  logic [PW-1:0] step;
  logic [WW-1:0] win_len;

  rmf_ctrl #(
    .MAX_WINDOW(MAX_WINDOW),
    .WW        (WW),
    .PW        (PW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .status  (status),
    .win_len (win_len),
    .cmd     (cmd),
    .step    (step)
  );

  rmf_datapath #(
    .MAX_WINDOW(MAX_WINDOW),
    .CHANNELS  (CHANNELS),
    .WW        (WW),
    .PW        (PW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .window_size  (window_size),
    .sample       (sample),
    .channel      (channel),
    .block_end    (block_end),
    .cmd          (cmd),
    .step         (step),
    .out_stall    (out_stall),
    .status       (status),
    .win_len      (win_len),
    .out_valid    (out_valid),
    .median       (median),
    .block_end_out(block_end_out)
  );

  assign in_stall  = !cmd.idle;
  assign cfg_ready = cmd.idle;

endmodule

// ----- src/rmf_ctrl.sv -----
// Controller state machine for the running median filter.
// Sequences history load, sort passes and result hand-off through rmf_cmd_t.
// Depends on rmf_pkg.
module rmf_ctrl
  import rmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int WW         = $clog2(MAX_WINDOW + 1),
  parameter int PW         = $clog2(MAX_WINDOW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rmf_status_t   status,
  input  logic [WW-1:0] win_len,
  output rmf_cmd_t      cmd,
  output logic [PW-1:0] step
);

  rmf_state_t    state;
  rmf_state_t    state_next;
  logic [PW-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!status.ch_ok) begin
          state_next = ST_FINISH;
        end else if (win_len == WW'(1)) begin
          state_next = ST_SORT;
          step_next  = '0;
        end else begin
          state_next = ST_LOAD;
          step_next  = PW'(win_len - WW'(2));
        end
      end
      ST_LOAD: begin
        if (step == '0) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step - PW'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_SORT;
        step_next  = '0;
      end
      ST_SORT: begin
        if (WW'(step) + WW'(1) == win_len) begin
          state_next = ST_FINISH;
        end else begin
          step_next = step + PW'(1);
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.idle    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.rd_en = 1'b1;
      end
      ST_SORT: begin
        cmd.sort_en  = 1'b1;
        cmd.wr_front = (step == '0);
      end
      ST_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/rmf_datapath.sv -----
// Datapath of the running median filter: history memory, window registers,
// odd-even transposition sort cells and the output register.
// Depends on rmf_pkg; driven by rmf_ctrl.
module rmf_datapath
  import rmf_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int WW         = $clog2(MAX_WINDOW + 1),
  parameter int PW         = $clog2(MAX_WINDOW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [WSIZE_W-1:0]         window_size,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CHAN_W-1:0]          channel,
  input  logic                       block_end,
  input  rmf_cmd_t                   cmd,
  input  logic [PW-1:0]              step,
  input  logic                       out_stall,
  output rmf_status_t                status,
  output logic [WW-1:0]              win_len,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] median,
  output logic                       block_end_out
);

  localparam int DEPTH = CHANNELS * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);

  logic [WSIZE_W-1:0]         wsize;
  logic [WW-1:0]              eff_len;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [CHAN_W-1:0]          ch_q;
  logic                       end_q;
  logic                       ch_ok;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           mem_vld;
  logic signed [SAMPLE_W-1:0] mem_q;
  logic                       mem_hit_q;
  logic                       rd_pend;
  logic [PW-1:0]              rd_pos_q;
  logic signed [SAMPLE_W-1:0] rd_val;

  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [PW-1:0]              wr_pos;
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] wr_data;

  logic signed [SAMPLE_W-1:0] win [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] win_next [MAX_WINDOW];
  logic [PW-1:0]              med_idx;
  logic signed [SAMPLE_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize <= WSIZE_RESET;
    end else if (cfg_valid && cmd.idle) begin
      wsize <= window_size;
    end
  end

  always_comb begin
    if (wsize == '0) begin
      eff_len = WW'(1);
    end else if (32'(wsize) > MAX_WINDOW) begin
      eff_len = WW'(MAX_WINDOW);
    end else begin
      eff_len = WW'(wsize);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= sample;
      ch_q     <= channel;
      end_q    <= block_end;
      ch_ok    <= (32'(channel) < CHANNELS);
      win_len  <= eff_len;
    end
  end

  assign rd_addr = AW'(32'(ch_q) * MAX_WINDOW + 32'(step));
  assign wr_pos  = cmd.wr_front ? '0 : rd_pos_q + PW'(1);
  assign wr_addr = AW'(32'(ch_q) * MAX_WINDOW + 32'(wr_pos));
  assign wr_en   = cmd.wr_front || rd_pend;
  assign rd_val  = mem_hit_q ? mem_q : '0;
  assign wr_data = cmd.wr_front ? sample_q : rd_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (wr_en) begin
      mem_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q     <= mem[rd_addr];
      mem_hit_q <= mem_vld[rd_addr];
      rd_pos_q  <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      win_next[i] = win[i];
    end
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if ((i % 2) == int'(step[0]) && (i + 1) < int'(win_len) && win[i] > win[i+1]) begin
        win_next[i]   = win[i+1];
        win_next[i+1] = win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      win[0] <= sample;
    end else if (rd_pend) begin
      win[wr_pos] <= rd_val;
    end else if (cmd.sort_en) begin
      win <= win_next;
    end
  end

  assign med_idx = PW'(win_len >> 1);
  assign result  = ch_ok ? win[med_idx] : sample_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      median        <= result;
      block_end_out <= end_q;
    end
  end

  assign status.ch_ok    = ch_ok;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ----- src/rmf_checker.sv -----
// Port-level checks for the running median filter, bound to the top level.
// Uses only the top-level ports; no package dependency.
module rmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] median,
  input logic        block_end_out
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median) && $stable(block_end_out))
    else $error("stalled result changed");

  // Each sample keeps the block busy, so the input closes after a transfer.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("input still open after a transfer");

  // A new result is only produced while a sample is being worked on.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // The configuration port is open exactly when the input is.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !in_stall)
    else $error("configuration port open while busy");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (.*);

// ----- sim/rmf_median_checker.sv -----
// Checker for the running median filter: watches the config, input and output transfers.
// Keeps its own per-channel histories, predicts each median and compares it with the DUT.
// Depends on rmf_pkg for widths and default sizes.
`timescale 1ns / 100ps

module rmf_median_checker
  import rmf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [WSIZE_W-1:0]         window_size,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CHAN_W-1:0]          channel,
  input  logic                       block_end,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] median,
  input  logic                       block_end_out,
  output int                         errors,
  output int                         pending
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic                       block_end;
  } median_result_t;

  logic [WSIZE_W-1:0]         wsize_model;
  logic signed [SAMPLE_W-1:0] history [DEF_CHANNELS][DEF_MAX_WINDOW];
  median_result_t             expected_medians [$];
  int                         mismatches;

  function automatic logic signed [SAMPLE_W-1:0] slide_and_pick_median(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [CHAN_W-1:0]          ch
  );
    int                         w;
    logic signed [SAMPLE_W-1:0] win [DEF_MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] t;
    if (ch >= DEF_CHANNELS) begin
      return s;
    end
    if (wsize_model == 0) begin
      w = 1;
    end else if (wsize_model > DEF_MAX_WINDOW) begin
      w = DEF_MAX_WINDOW;
    end else begin
      w = wsize_model;
    end
    for (int k = w - 1; k > 0; k--) begin
      history[ch][k] = history[ch][k-1];
    end
    history[ch][0] = s;
    for (int k = 0; k < w; k++) begin
      win[k] = history[ch][k];
    end
    for (int i = 0; i < w - 1; i++) begin
      for (int k = i + 1; k < w; k++) begin
        if (win[i] > win[k]) begin
          t = win[i];
          win[i] = win[k];
          win[k] = t;
        end
      end
    end
    return win[w/2];
  endfunction

  always @(posedge clk) begin
    median_result_t exp_r;
    median_result_t new_r;
    if (rst) begin
      wsize_model = WSIZE_RESET;
      for (int c = 0; c < DEF_CHANNELS; c++) begin
        for (int k = 0; k < DEF_MAX_WINDOW; k++) begin
          history[c][k] = '0;
        end
      end
      expected_medians.delete();
      mismatches = 0;
    end else begin
      // A result never leaves before its own input has passed the controller states,
      // so the output side is settled first.
      if (out_valid && !out_stall) begin
        if (expected_medians.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: median %0d, block end %0b", $realtime,
                     median, block_end_out);
          end
        end else begin
          exp_r = expected_medians.pop_front();
          if (exp_r.median !== median || exp_r.block_end !== block_end_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: median exp %0d got %0d, block end exp %0b got %0b",
                       $realtime, exp_r.median, median, exp_r.block_end, block_end_out);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        new_r.median    = slide_and_pick_median(sample, channel);
        new_r.block_end = block_end;
        expected_medians.push_back(new_r);
      end
      if (cfg_valid && cfg_ready) begin
        wsize_model = window_size;
      end
    end
    errors  <= mismatches;
    pending <= expected_medians.size();
  end

endmodule

// ----- sim/running_median_filter_tb.sv -----
// Testbench top for the running median filter: clock, reset, stimulus and verdict.
// Depends on rmf_pkg, the running_median_filter RTL and rmf_median_checker.
`timescale 1ns / 100ps

module running_median_filter_tb;
  import rmf_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 146;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [WSIZE_W-1:0]         window_size = WSIZE_RESET;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [CHAN_W-1:0]          channel = '0;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] median;
  logic                       block_end_out;

  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  logic calm = 1'b0;

  always #2 clk = ~clk;

  running_median_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_size   (window_size),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .channel       (channel),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .median        (median),
    .block_end_out (block_end_out)
  );

  rmf_median_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_size   (window_size),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .channel       (channel),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .median        (median),
    .block_end_out (block_end_out),
    .errors        (errors),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s,
                             input logic [CHAN_W-1:0] ch, input logic be);
    while (!calm && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    channel   <= ch;
    block_end <= be;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WSIZE_W-1:0] w);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    window_size <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5, 6:    return SAMPLE_W'($signed($urandom_range(8)) - 4);
      7:          return {1'b0, {(SAMPLE_W-1){1'b1}}};
      8:          return {1'b1, {(SAMPLE_W-1){1'b0}}};
      default:    return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  logic signed [SAMPLE_W-1:0] dir_samples [12] = '{
    24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
    24'sh000001, -24'sh000001, 24'sh000000, 24'sh555555, -24'sh2AAAAB, 24'sh7FFFFF
  };
  logic [CHAN_W-1:0] dir_channels [12] = '{0, 0, 1, 1, 2, 2, 3, 3, 0, 0, 0, 3};
  logic [WSIZE_W-1:0] phase_windows [13] = '{0, 15, 1, 9, 2, 8, 4, 10, 5, 7, 6, 3, 9};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window of three over all-zero histories.
    for (int i = 0; i < 12; i++) begin
      send_sample(dir_samples[i], dir_channels[i], i[0]);
    end
    // Window of zero behaves as one; above the maximum saturates.
    write_window(4'd0);
    send_sample(24'sh123456, 2'd1, 1'b0);
    send_sample(-24'sh000007, 2'd1, 1'b1);
    write_window(4'd15);
    send_sample(24'sh7FFFFF, 2'd2, 1'b0);
    send_sample(-24'sh800000, 2'd2, 1'b1);
    send_sample(24'sh000010, 2'd3, 1'b0);

    for (int p = 0; p < 13; p++) begin
      write_window(phase_windows[p]);
      calm = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_sample(pick_sample(), CHAN_W'($urandom_range(3)), ($urandom_range(7) == 0));
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
